FILE: hw/rtl/mqttpp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MQTT PUBLISH frame parser.
// Used by the front end, the queue, the back end and the top level.
package mqttpp_pkg;

   localparam int QueueDepth = 4;

   // Header byte fields
   localparam logic [7:0] HDR_TYPE_MASK = 8'hF0;
   localparam logic [7:0] HDR_PUBLISH   = 8'h30;
   localparam logic [7:0] HDR_QOS_MASK  = 8'h06;
   localparam logic [7:0] LEN_CONT_BIT  = 8'h80;
   localparam logic [2:0] LEN_MAX_BYTES = 3'd4;
   localparam logic [1:0] QOS_RESERVED  = 2'd3;
   localparam logic [1:0] QOS_ZERO      = 2'd0;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   typedef enum logic [2:0] {
      CLASS_HEADER   = 3'd0,
      CLASS_LENGTH   = 3'd1,
      CLASS_TOPICLEN = 3'd2,
      CLASS_TOPIC    = 3'd3,
      CLASS_PKTID    = 3'd4,
      CLASS_PAYLOAD  = 3'd5
   } byte_class_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_PUB   = 2'd1,
      STATUS_RSVD_QOS  = 2'd2,
      STATUS_MALFORMED = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      PH_HEADER  = 8'b0000_0001,
      PH_LENGTH  = 8'b0000_0010,
      PH_TLEN_HI = 8'b0000_0100,
      PH_TLEN_LO = 8'b0000_1000,
      PH_TOPIC   = 8'b0001_0000,
      PH_ID_HI   = 8'b0010_0000,
      PH_ID_LO   = 8'b0100_0000,
      PH_PAYLOAD = 8'b1000_0000
   } phase_type;

   // One classified byte as it passes from the front end to the back end.
   typedef struct packed {
      logic [7:0]     byte_value;
      byte_class_type byte_class;
      logic           frame_last;
      status_type     error_code;
      logic           at_payload;
      logic [1:0]     qos;
      logic [15:0]    packet_id;
      logic [15:0]    topic_size;
      logic [15:0]    payload_size;
   } item_type;

endpackage

FILE: hw/rtl/mqttpp_front.sv
`timescale 1ns / 1ps
// Front end: accepts frame bytes, runs the parse state and classifies each byte.
// Depends on mqttpp_pkg.
module mqttpp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] rx_byte
   input  logic               req_tlast,   // frame_last
   output logic               item_valid,
   input  logic               item_ready,
   output mqttpp_pkg::item_type item
);
   import mqttpp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  qos_ff, qos_in;
   logic [2:0]  len_cnt_ff, len_cnt_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [15:0] tcnt_ff, tcnt_in;
   logic [15:0] pid_ff, pid_in;
   logic [15:0] pcnt_ff, pcnt_in;
   status_type  err_ff, err_in;
   byte_class_type cls;
   phase_type   after_topic;
   logic [1:0]  hdr_qos;
   logic        accept;

   assign req_tready = item_ready;
   assign item_valid = req_tvalid;
   assign accept     = req_tvalid && item_ready;
   assign after_topic = (qos_ff == QOS_ZERO) ? PH_PAYLOAD : PH_ID_HI;
   assign hdr_qos     = 2'((req_tdata & HDR_QOS_MASK) >> 1);

   always_comb begin
      phase_in   = phase_ff;
      qos_in     = qos_ff;
      len_cnt_in = len_cnt_ff;
      tlen_in    = tlen_ff;
      tcnt_in    = tcnt_ff;
      pid_in     = pid_ff;
      pcnt_in    = pcnt_ff;
      err_in     = err_ff;
      cls        = CLASS_PAYLOAD;
      unique case (phase_ff)
         PH_HEADER: begin
            cls = CLASS_HEADER;
            if ((req_tdata & HDR_TYPE_MASK) != HDR_PUBLISH) begin
               err_in   = STATUS_NOT_PUB;
               phase_in = PH_PAYLOAD;
            end else if (hdr_qos == QOS_RESERVED) begin
               err_in   = STATUS_RSVD_QOS;
               phase_in = PH_PAYLOAD;
            end else begin
               qos_in     = hdr_qos;
               len_cnt_in = 3'd0;
               phase_in   = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            cls        = CLASS_LENGTH;
            len_cnt_in = len_cnt_ff + 3'd1;
            if ((req_tdata & LEN_CONT_BIT) == 8'd0) begin
               phase_in = PH_TLEN_HI;
            end else if (len_cnt_in >= LEN_MAX_BYTES) begin
               err_in   = STATUS_MALFORMED;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_TLEN_HI: begin
            cls      = CLASS_TOPICLEN;
            tlen_in  = {req_tdata, 8'd0};
            phase_in = PH_TLEN_LO;
         end
         PH_TLEN_LO: begin
            cls      = CLASS_TOPICLEN;
            tlen_in  = {tlen_ff[15:8], req_tdata};
            tcnt_in  = 16'd0;
            phase_in = (tlen_in == 16'd0) ? after_topic : PH_TOPIC;
         end
         PH_TOPIC: begin
            cls     = CLASS_TOPIC;
            tcnt_in = tcnt_ff + 16'd1;
            if (tcnt_in >= tlen_ff) begin
               phase_in = after_topic;
            end
         end
         PH_ID_HI: begin
            cls      = CLASS_PKTID;
            pid_in   = {req_tdata, 8'd0};
            phase_in = PH_ID_LO;
         end
         PH_ID_LO: begin
            cls      = CLASS_PKTID;
            pid_in   = {pid_ff[15:8], req_tdata};
            phase_in = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            cls = CLASS_PAYLOAD;
            if (err_ff == STATUS_OK && pcnt_ff != COUNT_MAX) begin
               pcnt_in = pcnt_ff + 16'd1;
            end
         end
         default: begin
            cls = CLASS_PAYLOAD;
         end
      endcase
   end

   always_comb begin
      item.byte_value   = req_tdata;
      item.byte_class   = cls;
      item.frame_last   = req_tlast;
      item.error_code   = err_in;
      item.at_payload   = (phase_in == PH_PAYLOAD);
      item.qos          = qos_in;
      item.packet_id    = pid_in;
      item.topic_size   = tlen_in;
      item.payload_size = pcnt_in;
   end

   // The final byte of a frame returns all parse state to its reset values.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         phase_ff   <= PH_HEADER;
         qos_ff     <= 2'd0;
         len_cnt_ff <= 3'd0;
         tlen_ff    <= 16'd0;
         tcnt_ff    <= 16'd0;
         pid_ff     <= 16'd0;
         pcnt_ff    <= 16'd0;
         err_ff     <= STATUS_OK;
      end else if (accept) begin
         phase_ff   <= phase_in;
         qos_ff     <= qos_in;
         len_cnt_ff <= len_cnt_in;
         tlen_ff    <= tlen_in;
         tcnt_ff    <= tcnt_in;
         pid_ff     <= pid_in;
         pcnt_ff    <= pcnt_in;
         err_ff     <= err_in;
      end
   end

endmodule

FILE: hw/rtl/mqttpp_queue.sv
`timescale 1ns / 1ps
// Short queue of classified bytes between the front end and the back end.
// Depends on mqttpp_pkg.
module mqttpp_queue #(
   parameter int Depth = mqttpp_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  mqttpp_pkg::item_type push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output mqttpp_pkg::item_type pop_item
);
   import mqttpp_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/mqttpp_back.sv
`timescale 1ns / 1ps
// Back end: turns a classified byte into a result beat with the frame summary.
// Depends on mqttpp_pkg.
module mqttpp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  mqttpp_pkg::item_type item,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import mqttpp_pkg::*;

   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic [2:0]  class_ff;
   logic        last_ff;
   status_type  status_ff, status_in;
   logic [1:0]  qos_ff, qos_in;
   logic [15:0] pid_ff, pid_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [15:0] plen_ff, plen_in;
   logic        load;

   assign item_ready = !valid_ff || rsp_tready;
   assign load       = item_valid && item_ready;

   // A held error wins; otherwise a frame that stops short of the payload is malformed.
   always_comb begin
      status_in = STATUS_OK;
      qos_in    = 2'd0;
      pid_in    = 16'd0;
      tlen_in   = 16'd0;
      plen_in   = 16'd0;
      if (item.frame_last) begin
         if (item.error_code != STATUS_OK) begin
            status_in = item.error_code;
         end else if (!item.at_payload) begin
            status_in = STATUS_MALFORMED;
         end
         if (status_in == STATUS_OK) begin
            qos_in  = item.qos;
            pid_in  = item.packet_id;
            tlen_in = item.topic_size;
            plen_in = item.payload_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (item_ready) begin
         valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= item.byte_value;
         class_ff  <= item.byte_class;
         last_ff   <= item.frame_last;
         status_ff <= status_in;
         qos_ff    <= qos_in;
         pid_ff    <= pid_in;
         tlen_ff   <= tlen_in;
         plen_ff   <= plen_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, plen_ff, tlen_ff, pid_ff, qos_ff, status_ff, byte_ff};
   assign rsp_tuser  = class_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: hw/rtl/mqtt_publish_parser_top.sv
`timescale 1ns / 1ps
// MQTT PUBLISH frame parser, one byte per beat on each side.
// An accepted request beat is held in a queue entry, then in the back-end output register.
// 1 byte per cycle unless queue full; parse state is one register stage, updated per byte.
// The QueueDepth-entry queue lets the front end accept while the output stalls, until full.
// Reset is synchronous and active high, and returns the parser to expect a fixed header.
module mqtt_publish_parser_top #(
   parameter int QueueDepth = mqttpp_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // frame_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] byte_value, [9:8] status, [11:10] qos_level,
                                    // [27:12] message_id, [43:28] topic_length,
                                    // [59:44] payload_length, [63:60] zero
   output logic [2:0]  rsp_tuser,   // [2:0] byte_class
   output logic        rsp_tlast    // frame_end
);
   import mqttpp_pkg::*;

   item_type front_item, back_item;
   logic     front_valid, front_ready;
   logic     back_valid, back_ready;

   mqttpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   mqttpp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   mqttpp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: dv/mqtt_publish_parser_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MQTT PUBLISH frame parser top level.
// Depends on mqttpp_pkg and mqtt_publish_parser_top; it predicts each response beat
// with its own byte-level parse model.
module mqtt_publish_parser_top_tb;
   import mqttpp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 20_000;
   localparam int unsigned SETTLE_TICKS = 20;

   typedef struct packed {
      logic       pause;
      logic [7:0] rx_byte;
      logic       frame_last;
   } rx_beat_type;

   typedef struct packed {
      logic [7:0]     byte_value;
      byte_class_type byte_class;
      logic           frame_end;
      status_type     status;
      logic [1:0]     qos_level;
      logic [15:0]    message_id;
      logic [15:0]    topic_length;
      logic [15:0]    payload_length;
   } parsed_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   rx_beat_type     pending_beats[$];
   parsed_byte_type parsed_bytes_due[$];

   // Model of the parse state
   phase_type   phase = PH_HEADER;
   logic [1:0]  qos_seen = '0;
   logic [2:0]  length_bytes = '0;
   logic [15:0] topic_size_seen = '0;
   logic [15:0] topic_bytes = '0;
   logic [15:0] packet_id_seen = '0;
   logic [15:0] payload_bytes = '0;
   status_type  frame_error = STATUS_OK;

   int unsigned cycle_count = 0;
   int unsigned beats_queued = 0;
   int unsigned beats_accepted = 0;
   int unsigned beats_checked = 0;
   int unsigned frames_clean = 0;
   int unsigned frames_flagged = 0;
   int unsigned longest_payload = 0;
   int unsigned mismatches = 0;
   logic        draining = 1'b0;
   logic        long_hold_done = 1'b0;
   int unsigned hold_left = 0;

   // Neither side inserts random idles inside this window.
   wire steady_window = (cycle_count >= 600) && (cycle_count < 1000);

   mqtt_publish_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic clear_parse_state();
      phase           = PH_HEADER;
      qos_seen        = '0;
      length_bytes    = '0;
      topic_size_seen = '0;
      topic_bytes     = '0;
      packet_id_seen  = '0;
      payload_bytes   = '0;
      frame_error     = STATUS_OK;
   endtask

   function automatic phase_type phase_after_topic();
      return (qos_seen == QOS_ZERO) ? PH_PAYLOAD : PH_ID_HI;
   endfunction

   task automatic parse_rx_byte(input logic [7:0] rx, input logic last,
                                output parsed_byte_type res);
      logic [1:0] qos;
      status_type st;
      res = '0;
      res.byte_value = rx;
      res.byte_class = CLASS_PAYLOAD;
      case (phase)
         PH_HEADER: begin
            res.byte_class = CLASS_HEADER;
            qos = rx[2:1];
            if ((rx & HDR_TYPE_MASK) != HDR_PUBLISH) begin
               frame_error = STATUS_NOT_PUB;
               phase = PH_PAYLOAD;
            end else if (qos == QOS_RESERVED) begin
               frame_error = STATUS_RSVD_QOS;
               phase = PH_PAYLOAD;
            end else begin
               qos_seen = qos;
               length_bytes = '0;
               phase = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            res.byte_class = CLASS_LENGTH;
            length_bytes = length_bytes + 3'd1;
            if ((rx & LEN_CONT_BIT) == 8'h00) begin
               phase = PH_TLEN_HI;
            end else if (length_bytes >= LEN_MAX_BYTES) begin
               frame_error = STATUS_MALFORMED;
               phase = PH_PAYLOAD;
            end
         end
         PH_TLEN_HI: begin
            res.byte_class = CLASS_TOPICLEN;
            topic_size_seen = {rx, 8'h00};
            phase = PH_TLEN_LO;
         end
         PH_TLEN_LO: begin
            res.byte_class = CLASS_TOPICLEN;
            topic_size_seen = topic_size_seen | {8'h00, rx};
            topic_bytes = '0;
            phase = (topic_size_seen == 16'd0) ? phase_after_topic() : PH_TOPIC;
         end
         PH_TOPIC: begin
            res.byte_class = CLASS_TOPIC;
            topic_bytes = topic_bytes + 16'd1;
            if (topic_bytes >= topic_size_seen) phase = phase_after_topic();
         end
         PH_ID_HI: begin
            res.byte_class = CLASS_PKTID;
            packet_id_seen = {rx, 8'h00};
            phase = PH_ID_LO;
         end
         PH_ID_LO: begin
            res.byte_class = CLASS_PKTID;
            packet_id_seen = packet_id_seen | {8'h00, rx};
            phase = PH_PAYLOAD;
         end
         default: begin
            // Discarded bytes of a rejected frame are not counted.
            if (frame_error == STATUS_OK && payload_bytes != COUNT_MAX)
               payload_bytes = payload_bytes + 16'd1;
         end
      endcase

      if (last) begin
         if (frame_error != STATUS_OK) st = frame_error;
         else if (phase != PH_PAYLOAD) st = STATUS_MALFORMED;
         else st = STATUS_OK;
         res.frame_end = 1'b1;
         res.status = st;
         if (st == STATUS_OK) begin
            res.qos_level      = qos_seen;
            res.message_id     = packet_id_seen;
            res.topic_length   = topic_size_seen;
            res.payload_length = payload_bytes;
         end
         clear_parse_state();
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_frame(input logic [7:0] frame[$]);
      rx_beat_type beat;
      foreach (frame[i]) begin
         beat.pause      = 1'b0;
         beat.rx_byte    = frame[i];
         beat.frame_last = (i == frame.size() - 1);
         pending_beats.push_back(beat);
      end
      beats_queued += frame.size();
   endtask

   // Mostly well-formed frames with random content; the rest carry a foreign
   // header, a reserved QoS, too many length bytes, an early end or pure noise.
   task automatic queue_random_frames(input int unsigned byte_budget);
      logic [7:0]  frame[$];
      logic [7:0]  b;
      logic [1:0]  qos;
      logic [15:0] tlen;
      int unsigned kind;
      int unsigned n_len;
      int unsigned n_payload;
      int unsigned cut;
      int unsigned queued;
      queued = 0;
      while (queued < byte_budget) begin
         kind = $urandom_range(99);
         qos = 2'($urandom_range(2));
         frame = {};
         if (kind < 6)
            frame.push_back(8'($urandom));
         else if (kind < 10)
            frame.push_back({HDR_PUBLISH[7:4], 1'($urandom), QOS_RESERVED, 1'($urandom)});
         else
            frame.push_back({HDR_PUBLISH[7:4], 1'($urandom), qos, 1'($urandom)});
         n_len = (kind >= 10 && kind < 15) ? $urandom_range(7, 5) : $urandom_range(4, 1);
         for (int i = 0; i < n_len; i++) begin
            b = 8'($urandom);
            b[7] = (i + 1 < n_len);
            frame.push_back(b);
         end
         if (kind >= 15 && kind < 25)
            tlen = 16'($urandom);
         else
            tlen = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(8, 1));
         frame.push_back(tlen[15:8]);
         frame.push_back(tlen[7:0]);
         for (int i = 0; i < tlen && i < 8; i++) frame.push_back(8'($urandom));
         if (qos != QOS_ZERO) begin
            frame.push_back(8'($urandom));
            frame.push_back(8'($urandom));
         end
         n_payload = ($urandom_range(15) == 0) ? $urandom_range(40, 20) : $urandom_range(12);
         repeat (n_payload) frame.push_back(8'($urandom));
         if (kind >= 15 && kind < 25) begin
            cut = $urandom_range(frame.size(), 1);
            frame = frame[0:cut-1];
         end else if (kind >= 25 && kind < 30) begin
            frame = {};
            repeat ($urandom_range(12, 1)) frame.push_back(8'($urandom));
         end
         queue_frame(frame);
         queued += frame.size();
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d beats outstanding.",
                  cycle_count, parsed_bytes_due.size());
         $display("mqtt_publish_parser_top_tb NOT OK");
         $finish;
      end
   end

   // Request driver
   always @(posedge clock) begin : drive_requests
      rx_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         draining   <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (draining) begin
            if (parsed_bytes_due.size() == 0) draining <= 1'b0;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() == 0
                      || (!steady_window && $urandom_range(99) < 17)) begin
            req_tvalid <= 1'b0;
         end else if (pending_beats[0].pause) begin
            void'(pending_beats.pop_front());
            draining   <= 1'b1;
            req_tvalid <= 1'b0;
         end else begin
            beat = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= beat.rx_byte;
            req_tlast  <= beat.frame_last;
         end
      end
   end

   // Response receiver, with one long hold-off once traffic is flowing.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!long_hold_done && beats_checked >= 150) begin
         long_hold_done <= 1'b1;
         hold_left      <= 200;
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= steady_window || ($urandom_range(99) >= 17);
      end
   end

   // Both channels are watched here so that a prediction is always queued
   // before the response it belongs to is checked.
   always @(posedge clock) begin : observe_beats
      parsed_byte_type due;
      if (reset) begin
         clear_parse_state();
      end else begin
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata, req_tlast, due);
            parsed_bytes_due.push_back(due);
            beats_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (parsed_bytes_due.size() == 0) begin
               $error("response beat 0x%0h arrived with nothing outstanding", rsp_tdata);
               mismatches++;
            end else begin
               due = parsed_bytes_due.pop_front();
               check_field("byte_value", due.byte_value, rsp_tdata[7:0]);
               check_field("status", due.status, rsp_tdata[9:8]);
               check_field("qos_level", due.qos_level, rsp_tdata[11:10]);
               check_field("message_id", due.message_id, rsp_tdata[27:12]);
               check_field("topic_length", due.topic_length, rsp_tdata[43:28]);
               check_field("payload_length", due.payload_length, rsp_tdata[59:44]);
               check_field("tdata padding", 0, rsp_tdata[63:60]);
               check_field("byte_class", due.byte_class, rsp_tuser);
               check_field("frame_end", due.frame_end, rsp_tlast);
               if (due.frame_end) begin
                  if (due.status == STATUS_OK) frames_clean++;
                  else frames_flagged++;
                  if (due.payload_length > longest_payload)
                     longest_payload = due.payload_length;
               end
            end
            beats_checked++;
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  frame[$];
      rx_beat_type pause_beat;
      pause_beat = '0;
      pause_beat.pause = 1'b1;

      // QoS 0 with an empty topic, ending on the topic length.
      frame = {HDR_PUBLISH, 8'h00, 8'h00, 8'h00};
      queue_frame(frame);
      // Not a PUBLISH: the rest of the frame is thrown away.
      frame = {8'hFF, 8'hAA, 8'h55};
      queue_frame(frame);
      // Reserved QoS.
      frame = {HDR_PUBLISH | 8'h06, 8'h01};
      queue_frame(frame);
      // Four length bytes that all ask for another one.
      frame = {HDR_PUBLISH | 8'h02, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
      queue_frame(frame);
      // Frame ends inside the length field.
      frame = {HDR_PUBLISH | 8'h04, 8'h85};
      queue_frame(frame);
      // QoS 1 ending on the packet identifier.
      frame = {HDR_PUBLISH | 8'h0B, 8'h04, 8'h00, 8'h01, 8'h41, 8'hFF, 8'h00};
      queue_frame(frame);

      pending_beats.push_back(pause_beat);
      queue_random_frames(400);
      pending_beats.push_back(pause_beat);
      queue_random_frames(400);

      // One frame at the extremes: the longest remaining length that is
      // allowed, QoS 2 and an all-ones identifier.
      frame = {HDR_PUBLISH | 8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h01, 8'h41,
               8'hFF, 8'hFF};
      repeat (5) frame.push_back(8'($urandom));
      queue_frame(frame);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (beats_accepted != beats_queued || parsed_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Checked %0d byte beats: %0d frames parsed clean, %0d frames flagged.",
               beats_checked, frames_clean, frames_flagged);
      $display("Longest payload count reported was %0d.", longest_payload);
      if (mismatches == 0)
         $display("mqtt_publish_parser_top_tb OK");
      else
         $display("mqtt_publish_parser_top_tb NOT OK");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/mqttpp_pkg.sv
hw/rtl/mqttpp_front.sv
hw/rtl/mqttpp_queue.sv
hw/rtl/mqttpp_back.sv
hw/rtl/mqtt_publish_parser_top.sv
dv/mqtt_publish_parser_top_tb.sv
